// File: src/mtkey_pkg.sv
package mtkey_pkg;

    localparam int KEY_COUNT = 9;

    localparam logic [3:0] NO_KEY     = 4'd15;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_BLANK = 8'h20;

    // Two-button command chords.
    localparam logic [KEY_COUNT-1:0] MASK_MODE  = 9'h030;
    localparam logic [KEY_COUNT-1:0] MASK_CLEAR = 9'h006;
    localparam logic [KEY_COUNT-1:0] MASK_BLANK = 9'h180;

    typedef struct packed {
        logic                 operation;
        logic [KEY_COUNT-1:0] buttons;
    } key_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic [4:0] char_index;
        logic       last;
        logic [5:0] text_length;
        logic       number_mode;
        logic       dot_glyph;
    } line_item_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic stream;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stream_done;
    } ctrl_stat_t;

    // Multi-tap letter table, three letters per key.
    function automatic logic [7:0] key_letter(input logic [3:0] key, input logic [1:0] tap);
        logic [23:0] row;
        case (key)
            4'd0:    row = {8'h2E, 8'h51, 8'h5A};
            4'd1:    row = {8'h41, 8'h42, 8'h43};
            4'd2:    row = {8'h44, 8'h45, 8'h46};
            4'd3:    row = {8'h47, 8'h48, 8'h49};
            4'd4:    row = {8'h4A, 8'h4B, 8'h4C};
            4'd5:    row = {8'h4D, 8'h4E, 8'h4F};
            4'd6:    row = {8'h50, 8'h52, 8'h53};
            4'd7:    row = {8'h54, 8'h55, 8'h56};
            4'd8:    row = {8'h57, 8'h58, 8'h59};
            default: row = 24'h0;
        endcase
        case (tap)
            2'd0:    return row[23:16];
            2'd1:    return row[15:8];
            2'd2:    return row[7:0];
            default: return 8'h0;
        endcase
    endfunction

endpackage

// File: src/mtkey_ram.sv
module mtkey_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/mtkey_ctrl.sv
module mtkey_ctrl
    import mtkey_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    output ctrl_cmd_t  cmd,
    input  ctrl_stat_t stat
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_STREAM;
            end
            ST_STREAM:
            begin
                if (stat.stream_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign key_stall   = (state_reg != ST_IDLE);
    assign cmd.capture = (state_reg == ST_IDLE) && key_valid;
    assign cmd.update  = (state_reg == ST_UPDATE);
    assign cmd.stream  = (state_reg == ST_STREAM);

    a_update_then_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (state_reg == ST_STREAM))
        else $error("update not followed by streaming");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.stream && stat.stream_done) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle");

endmodule

// File: src/mtkey_dp.sv
module mtkey_dp
    import mtkey_pkg::*;
#(
    parameter int LINE_CHARS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  key_item_t  key_item,
    input  ctrl_cmd_t  cmd,
    output ctrl_stat_t stat,
    output logic       line_valid,
    input  logic       line_stall,
    output line_item_t line_item
);

    localparam int N  = LINE_CHARS;
    localparam int IW = $clog2(N);
    localparam int LW = $clog2(N + 1);
    localparam int SW = LW + 1;

    // The line is kept as a ring: a scroll only moves the head.
    function automatic logic [IW-1:0] wrap_pos(input logic [SW-1:0] x);
        logic [SW-1:0] y;
        y = (x >= SW'(N)) ? x - SW'(N) : x;
        return y[IW-1:0];
    endfunction

    key_item_t   item_reg;
    logic [LW-1:0] len_reg, len_next;
    logic [IW-1:0] head_reg, head_next;
    logic [3:0]    last_btn_reg, last_btn_next;
    logic [1:0]    tap_reg, tap_next;
    logic          mode_reg, mode_next;
    logic          glyph_reg, glyph_next;

    logic [LW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          out_valid_reg, out_valid_next;
    line_item_t    out_reg;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          one_key;
    logic [3:0]    key_idx;
    logic [1:0]    tap_mod;
    logic          do_append;
    logic [7:0]    app_char;
    logic          load;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= key_item;
        end
    end

    assign one_key = (item_reg.buttons != '0)
                  && ((item_reg.buttons & (item_reg.buttons - 9'd1)) == '0);
    assign tap_mod = (tap_reg == 2'd3) ? 2'd0 : tap_reg;

    always_comb
    begin
        key_idx = 4'd0;
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (item_reg.buttons[i])
            begin
                key_idx = 4'(i);
            end
        end
    end

    always_comb
    begin
        len_next      = len_reg;
        head_next     = head_reg;
        last_btn_next = last_btn_reg;
        tap_next      = tap_reg;
        mode_next     = mode_reg;
        glyph_next    = glyph_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = 8'h0;
        do_append     = 1'b0;
        app_char      = 8'h0;
        if (cmd.update)
        begin
            if (item_reg.operation)
            begin
                len_next   = '0;
                head_next  = '0;
                glyph_next = 1'b0;
            end
            else if (one_key)
            begin
                if (mode_reg)
                begin
                    do_append = 1'b1;
                    app_char  = CHAR_ONE + {4'd0, key_idx};
                end
                else if ((key_idx != last_btn_reg) || (len_reg == '0))
                begin
                    do_append     = 1'b1;
                    app_char      = key_letter(key_idx, 2'd0);
                    last_btn_next = key_idx;
                    tap_next      = 2'd1;
                end
                else
                begin
                    // Repeat press rewrites the last character in place.
                    ram_we    = 1'b1;
                    ram_waddr = wrap_pos(SW'(head_reg) + SW'(len_reg) - SW'(1));
                    ram_wdata = key_letter(key_idx, tap_mod);
                    tap_next  = (tap_mod == 2'd2) ? 2'd0 : tap_mod + 2'd1;
                end
            end
            else if (item_reg.buttons == MASK_MODE)
            begin
                last_btn_next = NO_KEY;
                tap_next      = 2'd0;
                mode_next     = ~mode_reg;
                glyph_next    = ~mode_reg;
            end
            else if (item_reg.buttons == MASK_CLEAR)
            begin
                mode_next     = 1'b0;
                last_btn_next = NO_KEY;
                tap_next      = 2'd0;
                len_next      = '0;
                head_next     = '0;
            end
            else if (item_reg.buttons == MASK_BLANK)
            begin
                do_append = 1'b1;
                app_char  = CHAR_BLANK;
            end

            if (do_append)
            begin
                ram_we    = 1'b1;
                ram_wdata = app_char;
                if (len_reg == LW'(N))
                begin
                    // Full line: the oldest slot takes the new character.
                    ram_waddr = head_reg;
                    head_next = wrap_pos(SW'(head_reg) + SW'(1));
                end
                else
                begin
                    ram_waddr = wrap_pos(SW'(head_reg) + SW'(len_reg));
                    len_next  = len_reg + LW'(1);
                end
            end
        end
    end

    // Streaming: one read in flight in the RAM output register, one item in the output register.
    assign load      = pend_reg && (!out_valid_reg || !line_stall);
    assign ram_re    = cmd.stream && (rd_cnt_reg != LW'(N)) && (!pend_reg || load);
    assign ram_raddr = wrap_pos(SW'(head_reg) + SW'(rd_cnt_reg));

    always_comb
    begin
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg;
        if (cmd.update)
        begin
            rd_cnt_next = '0;
        end
        else if (ram_re)
        begin
            rd_cnt_next   = rd_cnt_reg + LW'(1);
            pend_next     = 1'b1;
            pend_idx_next = rd_cnt_reg[IW-1:0];
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !line_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            head_reg      <= '0;
            last_btn_reg  <= NO_KEY;
            tap_reg       <= 2'd0;
            mode_reg      <= 1'b0;
            glyph_reg     <= 1'b0;
            rd_cnt_reg    <= LW'(N);
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            head_reg      <= head_next;
            last_btn_reg  <= last_btn_next;
            tap_reg       <= tap_next;
            mode_reg      <= mode_next;
            glyph_reg     <= glyph_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.char_code   <= (LW'(pend_idx_reg) < len_reg) ? ram_rdata : 8'h0;
            out_reg.char_index  <= 5'(pend_idx_reg);
            out_reg.last        <= (pend_idx_reg == IW'(N - 1));
            out_reg.text_length <= 6'(len_reg);
            out_reg.number_mode <= mode_reg;
            out_reg.dot_glyph   <= glyph_reg;
        end
    end

    mtkey_ram #(
        .WIDTH (8),
        .DEPTH (N)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign stat.stream_done = (rd_cnt_reg == LW'(N)) && !pend_reg;
    assign line_valid       = out_valid_reg;
    assign line_item        = out_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg <= LW'(N)) && (rd_cnt_reg <= LW'(N)))
        else $error("length or read count beyond the line");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("line RAM written while streaming");

    a_load_from_pending: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(line_valid) |-> $past(pend_reg))
        else $error("output loaded without a pending read");

    a_update_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !pend_reg)
        else $error("line changed while a read was pending");

endmodule

// File: src/multitap_keypad_text_entry.sv
// Channel | Signals                          | Direction | Item
// key     | key_valid, key_stall, key_item   | in        | operation, button mask
// line    | line_valid, line_stall, line_item| out       | one line position per item
//
// Each key item passes through these steps: capture, update of the line RAM, one line
// position per cycle through the RAM read port while the line side does not stall, a move
// of the last read into the output register, and a return to idle.
// key_stall stays high from the capture until the controller is back in idle.
// Reset is asynchronous and active low; it empties the line without touching the RAM.
// Stalls on the line side hold the output register and pause the RAM reads.
module multitap_keypad_text_entry
    import mtkey_pkg::*;
#(
    parameter int LINE_CHARS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_stall,
    input  key_item_t  key_item,
    output logic       line_valid,
    input  logic       line_stall,
    output line_item_t line_item
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    mtkey_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_stall (key_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mtkey_dp #(
        .LINE_CHARS (LINE_CHARS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_item   (key_item),
        .cmd        (cmd),
        .stat       (stat),
        .line_valid (line_valid),
        .line_stall (line_stall),
        .line_item  (line_item)
    );

endmodule
